[src/bitmap_frame_allocator_assert.svh]
// Assertion macros used by the bitmap frame allocator top level.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bfa_pkg.sv]
// Shared types, constants and helper functions of the bitmap frame allocator.
// No dependencies; used by bfa_ctrl, bfa_dp and bitmap_frame_allocator.
`default_nettype none

package bfa_pkg;

  // Default geometry.
  localparam int BITMAP_WORDS_DEF = 1024;
  localparam int FRAME_SHIFT_DEF  = 12;

  // Field widths.
  localparam int CMD_W     = 2;
  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 80;

  // Register values after reset.
  localparam logic [CNT_W-1:0] RST_FRAME_COUNT = 16'd32768;
  localparam logic [CNT_W-1:0] RST_RESERVED    = 16'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK  = 2'd0,
    STATUS_OOM = 2'd1,
    STATUS_OOB = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COUNT = 1'b0,
    CFG_RESERVED    = 1'b1
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;        // latch the incoming word, clear the result
    logic init_start;  // snapshot the registers, restart the layout sweep
    logic sweep_step;  // write one layout word
    logic scan_start;  // start the free-bit scan at the hint
    logic read_scan;   // read the word under the scan pointer
    logic alloc_next;  // advance the scan pointer
    logic alloc_fail;  // report out of memory
    logic alloc_take;  // mark the found bit used and report its address
    logic read_free;   // read the word holding the frame to free
    logic free_oob;    // report a free beyond storage
    logic free_write;  // clear the frame's bit
    logic respond;     // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
    logic scan_stop;
    logic word_full;
    logic hit_ok;
    logic free_oob;
    logic out_busy;
  } dp_status_t;

  // Mask with the lowest n bits set, n from 0 to 32.
  function automatic logic [WORD_W-1:0] ones_below(input logic [5:0] n);
    logic [WORD_W-1:0] m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = (6'(i) < n);
    end
    return m;
  endfunction

  // Position of the lowest clear bit; only meaningful when one exists.
  function automatic logic [4:0] first_zero(input logic [WORD_W-1:0] w);
    logic [4:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[src/bitmap_frame_allocator.sv]
// Top level of the first-fit bitmap page-frame allocator.
// Uses bfa_pkg, bfa_ctrl, bfa_dp and bitmap_frame_allocator_assert.svh.
//
// Channel   Direction  Handshake              Payload
// s_axis    in         tvalid / tready        tuser: cmd; tdata: address
// m_axis    out        tvalid / tready        tuser: status; tdata: addr, counts
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One command at a time. Reset runs a layout pass of one bitmap word per cycle
// with s_axis_tready low; init runs the same pass. Allocate reads and checks
// each bitmap word in turn, from the lowest one that may hold a free frame,
// until it finds a free frame or passes the frame limit. Free reads the word
// and clears the frame's bit, or reports beyond storage. A result waits in the
// output register while m_axis_tready is low and holds back the next result.
`default_nettype none

module bitmap_frame_allocator #(
  parameter int BITMAP_WORDS = bfa_pkg::BITMAP_WORDS_DEF,
  parameter int FRAME_SHIFT  = bfa_pkg::FRAME_SHIFT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port.
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bfa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bfa_pkg::CNT_W-1:0]       cfg_data_i,
  // Command stream.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [bfa_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [31:0] address
  input  wire logic [bfa_pkg::CMD_W-1:0]       s_axis_tuser,   // [1:0] cmd
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [31:0] frame_address, [47:32] used_count, [63:48] free_count,
  // [79:64] total_count
  output logic [bfa_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  output logic [bfa_pkg::STATUS_W-1:0]         m_axis_tuser    // [1:0] status
);

  bfa_pkg::dp_cmd_t                 dp_cmd;
  bfa_pkg::dp_status_t              dp_st;
  bfa_pkg::status_e                 res_status;
  logic [bfa_pkg::ADDR_W-1:0]       res_addr;
  logic [bfa_pkg::CNT_W-1:0]        res_used;
  logic [bfa_pkg::CNT_W-1:0]        res_free;
  logic [bfa_pkg::CNT_W-1:0]        res_total;

  // Registers are always writable.
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  bfa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_cmd_i   (bfa_pkg::cmd_e'(s_axis_tuser)),
    .st_i      (dp_st),
    .cmd_o     (dp_cmd)
  );

  // Bitmap, counters and output register.
  bfa_dp #(
    .BITMAP_WORDS (BITMAP_WORDS),
    .FRAME_SHIFT  (FRAME_SHIFT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (bfa_pkg::cfg_reg_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .address_i   (s_axis_tdata[bfa_pkg::ADDR_W-1:0]),
    .cmd_i       (dp_cmd),
    .st_o        (dp_st),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_status_o  (res_status),
    .m_addr_o    (res_addr),
    .m_used_o    (res_used),
    .m_free_o    (res_free),
    .m_total_o   (res_total)
  );

  // Result word packing, first field in the lowest bits.
  assign m_axis_tdata = {res_total, res_free, res_used, res_addr};
  assign m_axis_tuser = res_status;

  `include "bitmap_frame_allocator_assert.svh"

  // A result never shows up in the cycle right after a command is taken.
  `BFA_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result appeared one cycle after accept")

  // Used and free counts always add up to the total.
  `BFA_ASSERT_IMPL(a_counts_sum, m_axis_tvalid, (16'(m_axis_tdata[47:32] + m_axis_tdata[63:48]) == m_axis_tdata[79:64]), "used plus free differs from total")

  // Only a successful allocation carries a frame address.
  `BFA_ASSERT_IMPL(a_addr_zero_on_error, m_axis_tvalid && (m_axis_tuser != bfa_pkg::STATUS_OK), (m_axis_tdata[31:0] == 32'd0), "nonzero frame address on error")

endmodule

`default_nettype wire

[src/bfa_ctrl.sv]
// Command sequencer of the bitmap frame allocator.
// Uses bfa_pkg for the command and status structs; drives bfa_dp.
`default_nettype none

module bfa_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_valid_i,
  output logic                     s_ready_o,
  input  wire bfa_pkg::cmd_e       s_cmd_i,
  input  wire bfa_pkg::dp_status_t st_i,
  output bfa_pkg::dp_cmd_t         cmd_o
);

  typedef enum logic [7:0] {
    CLEAR     = 8'b0000_0001,
    IDLE      = 8'b0000_0010,
    INIT      = 8'b0000_0100,
    ALLOC_RD  = 8'b0000_1000,
    ALLOC_CHK = 8'b0001_0000,
    FREE_RD   = 8'b0010_0000,
    FREE_WR   = 8'b0100_0000,
    RESP      = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      CLEAR: begin
        cmd_o.sweep_step = 1'b1;
        if (st_i.sweep_last) begin
          state_d = IDLE;
        end
      end
      IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.take = 1'b1;
          unique case (s_cmd_i)
            bfa_pkg::CMD_INIT: begin
              cmd_o.init_start = 1'b1;
              state_d = INIT;
            end
            bfa_pkg::CMD_ALLOC: begin
              cmd_o.scan_start = 1'b1;
              state_d = ALLOC_RD;
            end
            bfa_pkg::CMD_FREE: begin
              state_d = FREE_RD;
            end
            bfa_pkg::CMD_NOP: begin
              state_d = RESP;
            end
          endcase
        end
      end
      INIT: begin
        cmd_o.sweep_step = 1'b1;
        if (st_i.sweep_last) begin
          state_d = RESP;
        end
      end
      ALLOC_RD: begin
        if (st_i.scan_stop) begin
          cmd_o.alloc_fail = 1'b1;
          state_d = RESP;
        end else begin
          cmd_o.read_scan = 1'b1;
          state_d = ALLOC_CHK;
        end
      end
      ALLOC_CHK: begin
        priority if (st_i.word_full) begin
          cmd_o.alloc_next = 1'b1;
          state_d = ALLOC_RD;
        end else if (st_i.hit_ok) begin
          cmd_o.alloc_take = 1'b1;
          state_d = RESP;
        end else begin
          cmd_o.alloc_fail = 1'b1;
          state_d = RESP;
        end
      end
      FREE_RD: begin
        if (st_i.free_oob) begin
          cmd_o.free_oob = 1'b1;
          state_d = RESP;
        end else begin
          cmd_o.read_free = 1'b1;
          state_d = FREE_WR;
        end
      end
      FREE_WR: begin
        cmd_o.free_write = 1'b1;
        state_d = RESP;
      end
      RESP: begin
        if (!st_i.out_busy) begin
          cmd_o.respond = 1'b1;
          state_d = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  // State register; reset starts the layout sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[src/bfa_dp.sv]
// Datapath of the bitmap frame allocator: bitmap memory, counters and result.
// Uses bfa_pkg; sequenced by bfa_ctrl.
`default_nettype none

module bfa_dp #(
  parameter int BITMAP_WORDS = bfa_pkg::BITMAP_WORDS_DEF,
  parameter int FRAME_SHIFT  = bfa_pkg::FRAME_SHIFT_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire bfa_pkg::cfg_reg_e                cfg_index_i,
  input  wire logic [bfa_pkg::CNT_W-1:0]        cfg_data_i,
  input  wire logic [bfa_pkg::ADDR_W-1:0]       address_i,
  input  wire bfa_pkg::dp_cmd_t                 cmd_i,
  output bfa_pkg::dp_status_t                   st_o,
  input  wire logic                             m_ready_i,
  output logic                                  m_valid_o,
  output bfa_pkg::status_e                      m_status_o,
  output logic [bfa_pkg::ADDR_W-1:0]            m_addr_o,
  output logic [bfa_pkg::CNT_W-1:0]             m_used_o,
  output logic [bfa_pkg::CNT_W-1:0]             m_free_o,
  output logic [bfa_pkg::CNT_W-1:0]             m_total_o
);

  localparam int CNT_W        = bfa_pkg::CNT_W;
  localparam int ADDR_W       = bfa_pkg::ADDR_W;
  localparam int WORD_W       = bfa_pkg::WORD_W;
  localparam int WAW          = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int FW           = WAW + 5;
  localparam int CW           = ((FW > CNT_W) ? FW : CNT_W) + 1;
  localparam int STORE_FRAMES = BITMAP_WORDS * 32;
  localparam int LAST_WORD    = BITMAP_WORDS - 1;

  // Bitmap storage, one bit per frame, set means used.
  logic [WORD_W-1:0] bitmap_mem_q [BITMAP_WORDS];

  // Control state.
  logic [CNT_W-1:0] fc_cfg_q, fc_cfg_d;
  logic [CNT_W-1:0] rs_cfg_q, rs_cfg_d;
  logic [CNT_W-1:0] sfc_q, sfc_d;
  logic [CNT_W-1:0] sr_q, sr_d;
  logic [CNT_W-1:0] active_q, active_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [WAW-1:0]   sw_q, sw_d;
  logic [WAW:0]     hint_q, hint_d;
  logic             out_valid_q, out_valid_d;

  // Payload registers.
  logic [WAW:0]              wa_q, wa_d;
  logic [ADDR_W-1:0]         addr_q, addr_d;
  bfa_pkg::status_e          res_status_q, res_status_d;
  logic [ADDR_W-1:0]         res_addr_q, res_addr_d;
  logic [WORD_W-1:0]         rdata_q;
  bfa_pkg::status_e          out_status_q, out_status_d;
  logic [ADDR_W-1:0]         out_addr_q, out_addr_d;
  logic [CNT_W-1:0]          out_used_q, out_used_d;
  logic [CNT_W-1:0]          out_free_q, out_free_d;
  logic [CNT_W-1:0]          out_total_q, out_total_d;

  // Combinational terms.
  logic [CW-1:0]     lim;
  logic [CW-1:0]     scan_base;
  logic [4:0]        zero_bit;
  logic [FW-1:0]     hit_idx;
  logic [ADDR_W-1:0] free_idx;
  logic [WAW-1:0]    free_word;
  logic [4:0]        free_bit;
  logic [WORD_W-1:0] free_mask;
  logic              free_dec;
  logic [CW-1:0]     sw_base;
  logic [CW-1:0]     lo_diff, hi_diff;
  logic [5:0]        lo_n, hi_n;
  logic [WORD_W-1:0] layout_word;
  logic [CNT_W-1:0]  init_min;
  logic [CW-1:0]     init_hi;
  logic [CW-1:0]     init_extra;
  logic [CNT_W-1:0]  init_used;
  logic              mem_we;
  logic [WAW-1:0]    mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [WAW-1:0]    mem_raddr;

  // Allocation limit: active frames that have storage behind them.
  assign lim = (CW'(active_q) < CW'(STORE_FRAMES)) ? CW'(active_q) : CW'(STORE_FRAMES);

  // Scan of the word under the pointer.
  assign scan_base = CW'({wa_q, 5'b0});
  assign zero_bit  = bfa_pkg::first_zero(rdata_q);
  assign hit_idx   = {wa_q[WAW-1:0], zero_bit};

  // Frame to free, taken from the latched address.
  assign free_idx  = addr_q >> FRAME_SHIFT;
  assign free_word = free_idx[FW-1:5];
  assign free_bit  = free_idx[4:0];
  assign free_mask = WORD_W'(1) << free_bit;
  assign free_dec  = rdata_q[free_bit] && (free_idx < ADDR_W'(active_q)) && (used_q != '0);

  // Init layout of one word: a frame is free when below the frame count
  // and at or above the reserved count.
  assign sw_base = CW'({sw_q, 5'b0});
  assign lo_diff = CW'(sfc_q) - sw_base;
  assign hi_diff = CW'(sr_q) - sw_base;

  always_comb begin
    priority if (CW'(sfc_q) <= sw_base) begin
      lo_n = '0;
    end else if (lo_diff >= CW'(32)) begin
      lo_n = 6'd32;
    end else begin
      lo_n = lo_diff[5:0];
    end
    priority if (CW'(sr_q) <= sw_base) begin
      hi_n = '0;
    end else if (hi_diff >= CW'(32)) begin
      hi_n = 6'd32;
    end else begin
      hi_n = hi_diff[5:0];
    end
  end

  assign layout_word = ~(bfa_pkg::ones_below(lo_n) & ~bfa_pkg::ones_below(hi_n));

  // Used count after init: reserved frames plus frames without storage.
  assign init_min   = (sr_q < sfc_q) ? sr_q : sfc_q;
  assign init_hi    = (CW'(STORE_FRAMES) > CW'(sr_q)) ? CW'(STORE_FRAMES) : CW'(sr_q);
  assign init_extra = (CW'(sfc_q) > init_hi) ? (CW'(sfc_q) - init_hi) : '0;
  assign init_used  = CNT_W'(CW'(init_min) + init_extra);

  // Status back to the controller.
  always_comb begin
    st_o            = '0;
    st_o.sweep_last = (sw_q == WAW'(LAST_WORD));
    st_o.scan_stop  = (scan_base >= lim);
    st_o.word_full  = &rdata_q;
    st_o.hit_ok     = (CW'(hit_idx) < lim);
    st_o.free_oob   = (free_idx >= ADDR_W'(STORE_FRAMES));
    st_o.out_busy   = out_valid_q && !m_ready_i;
  end

  // Memory write and read port selection.
  always_comb begin
    mem_we    = cmd_i.sweep_step || cmd_i.alloc_take || cmd_i.free_write;
    mem_waddr = free_word;
    mem_wdata = rdata_q & ~free_mask;
    priority if (cmd_i.sweep_step) begin
      mem_waddr = sw_q;
      mem_wdata = layout_word;
    end else if (cmd_i.alloc_take) begin
      mem_waddr = wa_q[WAW-1:0];
      mem_wdata = rdata_q | (WORD_W'(1) << zero_bit);
    end else begin
      mem_waddr = free_word;
      mem_wdata = rdata_q & ~free_mask;
    end
    mem_re    = cmd_i.read_scan || cmd_i.read_free;
    mem_raddr = cmd_i.read_scan ? wa_q[WAW-1:0] : free_word;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= bitmap_mem_q[mem_raddr];
    end
  end

  // Configuration registers.
  always_comb begin
    fc_cfg_d = fc_cfg_q;
    rs_cfg_d = rs_cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bfa_pkg::CFG_FRAME_COUNT: fc_cfg_d = cfg_data_i;
        bfa_pkg::CFG_RESERVED:    rs_cfg_d = cfg_data_i;
        default: begin
          fc_cfg_d = fc_cfg_q;
        end
      endcase
    end
  end

  // Allocator state updates.
  always_comb begin
    sfc_d    = sfc_q;
    sr_d     = sr_q;
    active_d = active_q;
    used_d   = used_q;
    sw_d     = sw_q;
    hint_d   = hint_q;
    wa_d     = wa_q;
    if (cmd_i.init_start) begin
      sfc_d    = fc_cfg_q;
      sr_d     = rs_cfg_q;
      active_d = fc_cfg_q;
      sw_d     = '0;
      hint_d   = '0;
    end
    if (cmd_i.sweep_step) begin
      sw_d = sw_q + WAW'(1);
      if (sw_q == WAW'(LAST_WORD)) begin
        used_d = init_used;
      end
    end
    if (cmd_i.scan_start) begin
      wa_d = hint_q;
    end
    if (cmd_i.alloc_next) begin
      wa_d = wa_q + (WAW + 1)'(1);
    end
    if (cmd_i.alloc_fail) begin
      hint_d = wa_q;
    end
    if (cmd_i.alloc_take) begin
      hint_d = wa_q;
      used_d = used_q + CNT_W'(1);
    end
    if (cmd_i.free_write) begin
      if ({1'b0, free_word} < hint_q) begin
        hint_d = {1'b0, free_word};
      end
      if (free_dec) begin
        used_d = used_q - CNT_W'(1);
      end
    end
  end

  // Result being built for the current word.
  always_comb begin
    addr_d       = addr_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    if (cmd_i.take) begin
      addr_d       = address_i;
      res_status_d = bfa_pkg::STATUS_OK;
      res_addr_d   = '0;
    end
    if (cmd_i.alloc_fail) begin
      res_status_d = bfa_pkg::STATUS_OOM;
    end
    if (cmd_i.alloc_take) begin
      res_addr_d = ADDR_W'({hit_idx, {FRAME_SHIFT{1'b0}}});
    end
    if (cmd_i.free_oob) begin
      res_status_d = bfa_pkg::STATUS_OOB;
    end
  end

  // Output register.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    out_used_d   = out_used_q;
    out_free_d   = out_free_q;
    out_total_d  = out_total_q;
    if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.respond) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_addr_d   = res_addr_q;
      out_used_d   = used_q;
      out_free_d   = (active_q > used_q) ? (active_q - used_q) : '0;
      out_total_d  = active_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_cfg_q    <= bfa_pkg::RST_FRAME_COUNT;
      rs_cfg_q    <= bfa_pkg::RST_RESERVED;
      sfc_q       <= bfa_pkg::RST_FRAME_COUNT;
      sr_q        <= bfa_pkg::RST_RESERVED;
      active_q    <= bfa_pkg::RST_FRAME_COUNT;
      used_q      <= '0;
      sw_q        <= '0;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fc_cfg_q    <= fc_cfg_d;
      rs_cfg_q    <= rs_cfg_d;
      sfc_q       <= sfc_d;
      sr_q        <= sr_d;
      active_q    <= active_d;
      used_q      <= used_d;
      sw_q        <= sw_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q         <= wa_d;
    addr_q       <= addr_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
    out_used_q   <= out_used_d;
    out_free_q   <= out_free_d;
    out_total_q  <= out_total_d;
  end

  assign m_valid_o  = out_valid_q;
  assign m_status_o = out_status_q;
  assign m_addr_o   = out_addr_q;
  assign m_used_o   = out_used_q;
  assign m_free_o   = out_free_q;
  assign m_total_o  = out_total_q;

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_frame_allocator: init, allocate and free commands,
// register settings and random back-pressure, checked against an in-bench frame ledger.
// Depends on bfa_pkg and the bitmap_frame_allocator RTL only.

module tb;
  import bfa_pkg::*;

  localparam int unsigned MAP_WORDS  = BITMAP_WORDS_DEF;
  localparam int unsigned MAP_FRAMES = MAP_WORDS * 32;
  localparam int unsigned PAGE_SHIFT = FRAME_SHIFT_DEF;

  // One result word as the block reports it.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   frame_address;
    logic [CNT_W-1:0]    used_count;
    logic [CNT_W-1:0]    free_count;
    logic [CNT_W-1:0]    total_count;
  } alloc_report_t;

  // Mirror of the allocator state plus the reports still owed by the block.
  class frame_ledger;
    int unsigned   frame_count_reg;
    int unsigned   reserved_reg;
    int unsigned   active_frames;
    int unsigned   used_frames;
    logic [31:0]   usage_map [MAP_WORDS];
    alloc_report_t awaiting [$];
    int unsigned   mismatches;
    int unsigned   reported;
    int unsigned   checked;

    function new();
      frame_count_reg = RST_FRAME_COUNT;
      reserved_reg    = RST_RESERVED;
      mismatches      = 0;
      reported        = 0;
      checked         = 0;
      rebuild_layout();
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CNT_W-1:0] val);
      if (idx == CFG_FRAME_COUNT) frame_count_reg = val;
      else reserved_reg = val;
    endfunction

    // All used, then free below the frame count, then the reserved frames used.
    function void rebuild_layout();
      int unsigned clr, set_to, top;
      clr    = (frame_count_reg < MAP_FRAMES) ? frame_count_reg : MAP_FRAMES;
      set_to = (reserved_reg < MAP_FRAMES) ? reserved_reg : MAP_FRAMES;
      top    = (reserved_reg > MAP_FRAMES) ? reserved_reg : MAP_FRAMES;
      foreach (usage_map[w]) usage_map[w] = '1;
      for (int unsigned i = 0; i < clr; i++) usage_map[i >> 5][i & 31] = 1'b0;
      for (int unsigned i = 0; i < set_to; i++) usage_map[i >> 5][i & 31] = 1'b1;
      active_frames = frame_count_reg;
      used_frames = ((reserved_reg < frame_count_reg) ? reserved_reg : frame_count_reg) +
                    ((frame_count_reg > top) ? frame_count_reg - top : 0);
    endfunction

    // First fit below the active frame count; frames without storage never qualify.
    function bit lowest_free(output int unsigned idx);
      int unsigned lim;
      lim = (active_frames < MAP_FRAMES) ? active_frames : MAP_FRAMES;
      idx = 0;
      for (int unsigned w = 0; w < MAP_WORDS; w++) begin
        if (w * 32 >= lim) return 1'b0;
        if (usage_map[w] != '1) begin
          for (int unsigned b = 0; b < 32; b++) begin
            if (w * 32 + b >= lim) return 1'b0;
            if (!usage_map[w][b]) begin
              idx = w * 32 + b;
              return 1'b1;
            end
          end
        end
      end
      return 1'b0;
    endfunction

    // Advance the mirror by one accepted command and queue the report it owes.
    function void apply_command(cmd_e cmd, logic [ADDR_W-1:0] addr, output alloc_report_t rep);
      int unsigned idx;
      rep.status        = STATUS_OK;
      rep.frame_address = '0;
      case (cmd)
        CMD_INIT: rebuild_layout();
        CMD_ALLOC: begin
          if (lowest_free(idx)) begin
            usage_map[idx >> 5][idx & 31] = 1'b1;
            used_frames++;
            rep.frame_address = idx << PAGE_SHIFT;
          end else begin
            rep.status = STATUS_OOM;
          end
        end
        CMD_FREE: begin
          idx = addr >> PAGE_SHIFT;
          if (idx >= MAP_FRAMES) begin
            rep.status = STATUS_OOB;
          end else begin
            // Only a used frame inside the active range lowers the count.
            if (usage_map[idx >> 5][idx & 31] && idx < active_frames && used_frames > 0)
              used_frames--;
            usage_map[idx >> 5][idx & 31] = 1'b0;
          end
        end
        default: ;
      endcase
      rep.used_count  = used_frames[CNT_W-1:0];
      rep.free_count  = (active_frames > used_frames) ? CNT_W'(active_frames - used_frames) : '0;
      rep.total_count = active_frames[CNT_W-1:0];
      awaiting.push_back(rep);
    endfunction

    function int pending();
      return awaiting.size();
    endfunction

    // Compare one delivered result word with the oldest owed report.
    function void compare_report(logic [STATUS_W-1:0] st, logic [M_TDATA_W-1:0] data);
      alloc_report_t want, got;
      got.status        = st;
      got.frame_address = data[31:0];
      got.used_count    = data[47:32];
      got.free_count    = data[63:48];
      got.total_count   = data[79:64];
      checked++;
      if (awaiting.size() == 0) begin
        mismatches++;
        if (reported < 10) begin
          reported++;
          $display("%0t: result with none owed: status %0d addr %h used %0d free %0d total %0d",
                   $time, got.status, got.frame_address, got.used_count, got.free_count,
                   got.total_count);
        end
        return;
      end
      want = awaiting.pop_front();
      if (got !== want) begin
        mismatches++;
        if (reported < 10) begin
          reported++;
          $display("%0t: mismatch: expected status %0d addr %h used %0d free %0d total %0d",
                   $time, want.status, want.frame_address, want.used_count,
                   want.free_count, want.total_count);
          $display("%0t:           actual   status %0d addr %h used %0d free %0d total %0d",
                   $time, got.status, got.frame_address, got.used_count,
                   got.free_count, got.total_count);
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CNT_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0]     s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;

  frame_ledger ledger = new();

  int unsigned held_frames [$];
  int          burst_left = 1;
  bit          tx_gappy = 1'b1;
  int unsigned rx_cnt = 0;
  int unsigned rx_mode = 0;
  int unsigned n_init = 0, n_alloc = 0, n_oom = 0, n_free = 0, n_oob = 0, n_nop = 0;
  int unsigned n_settings = 0;

  bitmap_frame_allocator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver back-pressure in one of four patterns, chosen at random.
  always @(posedge clk_i) begin
    rx_cnt++;
    if (rx_cnt % 400 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 9) < 7);
      2: m_axis_tready <= ((rx_cnt % 13) >= 5);
      default: m_axis_tready <= ($urandom_range(0, 19) == 0);
    endcase
  end

  // Every accepted result word goes to the ledger.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) ledger.compare_report(m_axis_tuser, m_axis_tdata);
  end

  // When tx_gappy is set, bursts of back-to-back words with random gaps in between.
  task automatic pace_sender();
    if (tx_gappy) begin
      burst_left--;
      if (burst_left <= 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  // Offer one command word and wait until it is taken.
  task automatic send_item(cmd_e cmd, logic [ADDR_W-1:0] addr);
    alloc_report_t rep;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= addr;
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.apply_command(cmd, addr, rep);
    case (cmd)
      CMD_INIT: begin
        n_init++;
        held_frames.delete();
      end
      CMD_ALLOC: begin
        n_alloc++;
        if (rep.status == STATUS_OOM) n_oom++;
        else held_frames.push_back(rep.frame_address >> PAGE_SHIFT);
      end
      CMD_FREE: begin
        n_free++;
        if (rep.status == STATUS_OOB) n_oob++;
      end
      default: n_nop++;
    endcase
    pace_sender();
  endtask

  // Wait for the block to drain, then write the selected registers.
  task automatic begin_setting(int unsigned fc, int unsigned rsv, logic [1:0] which);
    cfg_reg_e reg_sel;
    s_axis_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    for (int r = 0; r < 2; r++) begin
      if (which[r]) begin
        reg_sel = (r == 0) ? CFG_FRAME_COUNT : CFG_RESERVED;
        cfg_valid_i <= 1'b1;
        cfg_index_i <= reg_sel;
        cfg_data_i  <= (r == 0) ? fc[CNT_W-1:0] : rsv[CNT_W-1:0];
        do @(posedge clk_i); while (!cfg_ready_o);
        ledger.write_reg(reg_sel, (r == 0) ? fc[CNT_W-1:0] : rsv[CNT_W-1:0]);
      end
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // Mostly allocate and free of held frames, with stray frees, inits and no-ops mixed in.
  task automatic run_random(int unsigned count);
    int unsigned pick, idx, k;
    logic [ADDR_W-1:0] addr;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_item(CMD_INIT, $urandom());
      end else if (pick < 48) begin
        send_item(CMD_ALLOC, $urandom());
      end else if (pick < 80 && held_frames.size() > 0) begin
        k = $urandom_range(0, held_frames.size() - 1);
        idx = held_frames[k];
        held_frames.delete(k);
        send_item(CMD_FREE, (idx << PAGE_SHIFT) | $urandom_range(0, 4095));
      end else if (pick < 90) begin
        // Anywhere around the active range: free, reserved or above the count.
        idx = $urandom_range(0, ledger.active_frames + 40);
        if (idx >= MAP_FRAMES) idx = $urandom_range(0, MAP_FRAMES - 1);
        send_item(CMD_FREE, (idx << PAGE_SHIFT) | $urandom_range(0, 4095));
      end else if (pick < 95) begin
        addr = $urandom();
        if ((addr >> PAGE_SHIFT) < MAP_FRAMES) addr[31] = 1'b1;
        send_item(CMD_FREE, addr);
      end else begin
        send_item(CMD_NOP, $urandom());
      end
    end
  endtask

  initial begin
    int unsigned fc_val, rsv_val;
    logic [1:0]  which;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset layout: first fit above the reserved frames, frees of odd addresses.
    send_item(CMD_NOP, 32'h0000_0000);
    send_item(CMD_ALLOC, 32'hFFFF_FFFF);
    send_item(CMD_FREE, 32'h0040_0123);
    send_item(CMD_FREE, 32'hFFFF_FFFF);
    send_item(CMD_FREE, 32'h07FF_F000);
    send_item(CMD_FREE, 32'h0000_0000);
    send_item(CMD_ALLOC, 32'h0000_0000);
    send_item(CMD_NOP, 32'hFFFF_FFFF);

    // No frames at all.
    begin_setting(0, 0, 2'b11);
    send_item(CMD_INIT, 32'h0);
    send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_FREE, 32'h0000_1000);

    // Every frame reserved: out of memory until one is freed.
    begin_setting(32768, 32768, 2'b11);
    send_item(CMD_INIT, 32'h0);
    send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_FREE, 32'd20000 << PAGE_SHIFT);
    send_item(CMD_ALLOC, 32'h0);

    // More reserved than present: frees above the count leave the counter alone.
    begin_setting(5, 10, 2'b11);
    send_item(CMD_INIT, 32'h0);
    send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_FREE, 32'd7 << PAGE_SHIFT);
    send_item(CMD_FREE, (32'd3 << PAGE_SHIFT) | 32'hFFF);
    send_item(CMD_ALLOC, 32'h0);

    // A register write without init changes nothing yet.
    begin_setting(100, 0, 2'b01);
    send_item(CMD_ALLOC, 32'h0);

    // Random phases, the first three at the register extremes.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin fc_val = 32768; rsv_val = 0;     which = 2'b11; end
        1: begin fc_val = 32768; rsv_val = 32768; which = 2'b11; end
        2: begin fc_val = 0;     rsv_val = 32768; which = 2'b11; end
        default: begin
          fc_val  = $urandom_range(1, 300);
          rsv_val = $urandom_range(0, fc_val + 20);
          which   = $urandom_range(1, 3);
        end
      endcase
      tx_gappy = (p % 3 != 2);
      begin_setting(fc_val, rsv_val, which);
      if (p < 3 || $urandom_range(0, 1)) send_item(CMD_INIT, $urandom());
      run_random(210);
    end

    s_axis_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Ran %0d register settings: %0d inits, %0d allocations (%0d out of memory),",
             n_settings, n_init, n_alloc, n_oom);
    $display("%0d frees (%0d beyond storage), %0d no-ops; %0d results checked, %0d mismatches.",
             n_free, n_oob, n_nop, ledger.checked, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: 200 ms of simulated time, far beyond the slowest legal run.
  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/bfa_pkg.sv
src/bfa_ctrl.sv
src/bfa_dp.sv
src/bitmap_frame_allocator.sv
tb/tb.sv
